@@ rtl/core/tt_pkg.sv @@
package tt_pkg;

    // token store
    localparam int TOKEN_MAX = 63;
    localparam int LEN_W     = $clog2(TOKEN_MAX + 1);
    localparam int IDX_W     = $clog2(TOKEN_MAX);

    // payload widths
    localparam int CHAR_W      = 8;
    localparam int LINE_W      = 20;
    localparam int OUT_TDATA_W = ((CHAR_W + LINE_W + 7) / 8) * 8;
    localparam int TDATA_PAD   = OUT_TDATA_W - CHAR_W - LINE_W;

    localparam logic [LINE_W-1:0] LINE_MAX   = '1;
    localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;
    localparam int SPEC_W     = 63;
    localparam int CMT_W      = 16;
    localparam int CMT_LEN_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_A     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_B     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_CHARS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_LEN   = CFG_IDX_W'(3);

    localparam logic [SPEC_W-1:0]    SPECIAL_A_RST   = 63'd4405711396330306939;
    localparam logic [SPEC_W-1:0]    SPECIAL_B_RST   = 63'd47;
    localparam logic [CMT_W-1:0]     COMMENT_CHR_RST = 16'd12079;
    localparam logic [CMT_LEN_W-1:0] COMMENT_LEN_RST = 2'd2;

    // characters
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
    localparam logic [CHAR_W-1:0] BOM_0    = 8'hEF;
    localparam logic [CHAR_W-1:0] BOM_1    = 8'hBB;
    localparam logic [CHAR_W-1:0] BOM_2    = 8'hBF;

    localparam logic [1:0] BOM_DONE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FEED,
        S_PROC,
        S_ADD,
        S_EMIT_RD,
        S_EMIT_WR,
        S_NEXT,
        S_FLUSH,
        S_RESTART
    } t_state;

    // where a token emission returns to
    typedef enum logic [1:0] {
        RET_ADD,
        RET_NEXT,
        RET_RESTART
    } t_ret;

    typedef struct packed {
        logic accept;
        logic load_feed;
        logic load_held;
        logic comment_start;
        logic proc;
        logic add_char;
        logic line_inc;
        logic emit_wr;
        logic tok_clear;
        logic restart;
    } t_cmd;

    typedef struct packed {
        logic bom_hit;
        logic last;
        logic held_valid;
        logic held_comment;
        logic feed_more;
        logic tok_empty;
        logic emit_last;
        logic out_free;
        logic fin1;
        logic add;
        logic fin2;
        logic line_inc;
    } t_status;

endpackage

@@ rtl/core/tt_ctrl.sv @@
module tt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tt_pkg::t_status  i_st,
    output tt_pkg::t_cmd     o_cmd
);
    import tt_pkg::*;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic   r_then_x, n_then_x;
    logic   r_add, n_add;
    logic   r_fin2, n_fin2;
    logic   r_line_inc, n_line_inc;

    function automatic t_state ret_state(input t_ret r);
        t_state s;
        unique case (r)
            RET_ADD:     s = S_ADD;
            RET_NEXT:    s = S_NEXT;
            RET_RESTART: s = S_RESTART;
            default:     s = S_IDLE;
        endcase
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= RET_NEXT;
            r_then_x   <= 1'b0;
            r_add      <= 1'b0;
            r_fin2     <= 1'b0;
            r_line_inc <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_then_x   <= n_then_x;
            r_add      <= n_add;
            r_fin2     <= n_fin2;
            r_line_inc <= n_line_inc;
        end
    end

    always_comb begin : next_state
        n_state    = r_state;
        n_ret      = r_ret;
        n_then_x   = r_then_x;
        n_add      = r_add;
        n_fin2     = r_fin2;
        n_line_inc = r_line_inc;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_st.bom_hit) begin
                    n_state = S_FEED;
                end
            end
            S_FEED: begin
                if (i_st.held_valid && i_st.held_comment) begin
                    // held lead byte plus this byte form the comment prefix
                    n_add      = 1'b0;
                    n_fin2     = 1'b0;
                    n_line_inc = 1'b0;
                    n_ret      = RET_ADD;
                    n_state    = i_st.tok_empty ? S_ADD : S_EMIT_RD;
                end else begin
                    n_then_x = i_st.held_valid;
                    n_state  = S_PROC;
                end
            end
            S_PROC: begin
                n_add      = i_st.add;
                n_fin2     = i_st.fin2;
                n_line_inc = i_st.line_inc;
                if (i_st.fin1) begin
                    n_ret   = RET_ADD;
                    n_state = i_st.tok_empty ? S_ADD : S_EMIT_RD;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_fin2) begin
                    n_ret   = RET_NEXT;
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (i_st.out_free) begin
                    n_state = i_st.emit_last ? ret_state(r_ret) : S_EMIT_RD;
                end
            end
            S_NEXT: begin
                priority if (r_then_x) begin
                    n_then_x = 1'b0;
                    n_state  = S_PROC;
                end else if (i_st.feed_more) begin
                    n_state = S_FEED;
                end else if (i_st.last) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_st.held_valid) begin
                    n_state = S_PROC;
                end else begin
                    n_ret   = RET_RESTART;
                    n_state = i_st.tok_empty ? S_RESTART : S_EMIT_RD;
                end
            end
            S_RESTART: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin : outputs
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_FEED: begin
                priority if (i_st.held_valid && i_st.held_comment) begin
                    o_cmd.comment_start = 1'b1;
                    o_cmd.tok_clear     = i_st.tok_empty;
                end else if (i_st.held_valid) begin
                    o_cmd.load_held = 1'b1;
                end else begin
                    o_cmd.load_feed = 1'b1;
                end
            end
            S_PROC: begin
                o_cmd.proc      = 1'b1;
                o_cmd.tok_clear = i_st.fin1 && i_st.tok_empty;
            end
            S_ADD: begin
                o_cmd.add_char = r_add;
                o_cmd.line_inc = r_line_inc;
            end
            S_EMIT_RD: begin
                o_cmd = '0;
            end
            S_EMIT_WR: begin
                o_cmd.emit_wr = i_st.out_free;
            end
            S_NEXT: begin
                o_cmd.load_feed = r_then_x;
            end
            S_FLUSH: begin
                if (i_st.held_valid) begin
                    o_cmd.load_held = 1'b1;
                end else begin
                    o_cmd.tok_clear = i_st.tok_empty;
                end
            end
            S_RESTART: begin
                o_cmd.restart = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/tt_datapath.sv @@
module tt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tt_pkg::CHAR_W-1:0]     i_in_byte,
    input  logic                          i_in_last,
    input  logic                          i_cfg_valid,
    input  logic [tt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  tt_pkg::t_cmd                  i_cmd,
    output tt_pkg::t_status               o_st,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tt_pkg::CHAR_W-1:0]     o_out_char,
    output logic                          o_out_end,
    output logic [tt_pkg::LINE_W-1:0]     o_out_line,
    output logic                          o_out_trunc
);
    import tt_pkg::*;

    // configuration
    logic [SPEC_W-1:0]    r_spec_a;
    logic [SPEC_W-1:0]    r_spec_b;
    logic [CMT_W-1:0]     r_cmt_chars;
    logic [CMT_LEN_W-1:0] r_cmt_len;

    // tokenizer state
    logic [LEN_W-1:0]  r_len;
    logic              r_ovf;
    logic [LINE_W-1:0] r_line;
    logic [CHAR_W-1:0] r_held;
    logic              r_held_v;
    logic              r_in_cmt;
    logic              r_after_cr;
    logic [1:0]        r_bom_prog;
    logic              r_bom_seen;

    // current request and feed sequence
    logic [CHAR_W-1:0] r_byte;
    logic              r_last;
    logic [1:0]        r_fk;
    logic [1:0]        r_fp;
    logic [CHAR_W-1:0] r_op;
    logic              r_mh;

    // token memory and emission
    logic [CHAR_W-1:0] r_store [TOKEN_MAX];
    logic [CHAR_W-1:0] r_rd_data;
    logic [IDX_W-1:0]  r_idx;

    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_end;
    logic [LINE_W-1:0] r_out_line;
    logic              r_out_trunc;

    logic              plen1, plen2;
    logic [CHAR_W-1:0] c0, c1;
    logic [CHAR_W-1:0] bom_mark;
    logic              bom_hit;
    logic [CHAR_W-1:0] feed_byte;
    logic              emit_last;
    logic              out_free;
    logic [CHAR_W-1:0] add_byte;
    logic              do_restart;

    logic d_fin1, d_add, d_fin2, d_line;
    logic d_set_cmt, d_clr_cmt, d_hold, d_newline;
    logic is_ws, is_nl, is_spec, swallow;

    function automatic logic is_special(input logic [CHAR_W-1:0] b,
                                        input logic [SPEC_W-1:0] a,
                                        input logic [SPEC_W-1:0] c);
        logic [2*SPEC_W+1:0] slots;
        logic                hit;
        slots = {1'b0, c, 1'b0, a};
        hit   = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if (slots[CHAR_W*i +: CHAR_W] == b) begin
                hit = 1'b1;
            end
        end
        return hit && (b != '0);
    endfunction

    assign plen1 = (r_cmt_len == CMT_LEN_W'(1));
    assign plen2 = r_cmt_len[1];
    assign c0    = r_cmt_chars[CHAR_W-1:0];
    assign c1    = r_cmt_chars[2*CHAR_W-1:CHAR_W];

    always_comb begin
        unique case (r_bom_prog)
            2'd0:    bom_mark = BOM_0;
            2'd1:    bom_mark = BOM_1;
            default: bom_mark = BOM_2;
        endcase
    end

    // a mark byte only counts if the text does not end before the mark is whole
    assign bom_hit = (r_bom_prog != BOM_DONE) && (i_in_byte == bom_mark)
                     && !(i_in_last && (r_bom_prog != 2'd2));

    // replayed mark bytes come first, then the request byte
    assign feed_byte = (r_fp == r_fk) ? r_byte : ((r_fp == 2'd0) ? BOM_0 : BOM_1);

    assign emit_last = ((LEN_W'(r_idx) + LEN_W'(1)) == r_len);
    assign out_free  = !r_out_valid || i_out_ready;
    assign add_byte  = (!r_bom_seen && r_op[CHAR_W-1]) ? CH_QMARK : r_op;
    assign do_restart = i_cmd.restart || (i_cmd.accept && bom_hit && i_in_last);

    assign is_ws   = (r_op == CH_SP) || (r_op == CH_TAB);
    assign is_nl   = (r_op == CH_LF) || (r_op == CH_CR);
    assign is_spec = is_special(r_op, r_spec_a, r_spec_b);
    assign swallow = r_after_cr && (r_op == CH_LF);

    always_comb begin : decide
        d_fin1    = 1'b0;
        d_add     = 1'b0;
        d_fin2    = 1'b0;
        d_line    = 1'b0;
        d_set_cmt = 1'b0;
        d_clr_cmt = 1'b0;
        d_hold    = 1'b0;
        d_newline = 1'b0;
        if (!swallow) begin
            priority if (r_in_cmt) begin
                if (is_nl) begin
                    d_clr_cmt = 1'b1;
                    d_fin1    = 1'b1;
                    d_line    = 1'b1;
                    d_newline = 1'b1;
                end
            end else if (plen1 && r_op == c0) begin
                d_fin1    = 1'b1;
                d_set_cmt = 1'b1;
            end else if (plen2 && r_op == c0 && r_mh) begin
                // hold the lead byte until the next one decides
                d_fin1 = is_ws || is_nl || is_spec;
                d_hold = 1'b1;
            end else if (is_ws) begin
                d_fin1 = 1'b1;
            end else if (is_nl) begin
                d_fin1    = 1'b1;
                d_line    = 1'b1;
                d_newline = 1'b1;
            end else if (is_spec) begin
                d_fin1 = 1'b1;
                d_add  = 1'b1;
                d_fin2 = 1'b1;
            end else begin
                d_add = 1'b1;
            end
        end
    end

    always_comb begin
        o_st.bom_hit      = bom_hit;
        o_st.last         = r_last;
        o_st.held_valid   = r_held_v;
        o_st.held_comment = plen2 && (feed_byte == c1);
        o_st.feed_more    = (r_fp <= r_fk);
        o_st.tok_empty    = (r_len == '0);
        o_st.emit_last    = emit_last;
        o_st.out_free     = out_free;
        o_st.fin1         = d_fin1;
        o_st.add          = d_add;
        o_st.fin2         = d_fin2;
        o_st.line_inc     = d_line;
    end

    // token memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_char && (r_len < LEN_W'(TOKEN_MAX))) begin
            r_store[r_len[IDX_W-1:0]] <= add_byte;
        end
        r_rd_data <= r_store[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spec_a    <= SPECIAL_A_RST;
            r_spec_b    <= SPECIAL_B_RST;
            r_cmt_chars <= COMMENT_CHR_RST;
            r_cmt_len   <= COMMENT_LEN_RST;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_line      <= LINE_FIRST;
            r_held      <= '0;
            r_held_v    <= 1'b0;
            r_in_cmt    <= 1'b0;
            r_after_cr  <= 1'b0;
            r_bom_prog  <= '0;
            r_bom_seen  <= 1'b0;
            r_last      <= 1'b0;
            r_fk        <= '0;
            r_fp        <= '0;
            r_mh        <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SPECIAL_A:     r_spec_a    <= i_cfg_data[SPEC_W-1:0];
                    CFG_SPECIAL_B:     r_spec_b    <= i_cfg_data[SPEC_W-1:0];
                    CFG_COMMENT_CHARS: r_cmt_chars <= i_cfg_data[CMT_W-1:0];
                    CFG_COMMENT_LEN:   r_cmt_len   <= i_cfg_data[CMT_LEN_W-1:0];
                    default:           r_cmt_len   <= r_cmt_len;
                endcase
            end

            if (i_cmd.accept) begin
                r_byte <= i_in_byte;
                r_last <= i_in_last;
                r_fp   <= '0;
                if (r_bom_prog != BOM_DONE) begin
                    if (bom_hit) begin
                        r_bom_prog <= r_bom_prog + 2'd1;
                        if (r_bom_prog == 2'd2) begin
                            r_bom_seen <= 1'b1;
                        end
                    end else begin
                        // mark broke off: replay the bytes matched so far
                        r_bom_prog <= BOM_DONE;
                        r_bom_seen <= 1'b0;
                        r_fk       <= r_bom_prog;
                    end
                end else begin
                    r_fk <= '0;
                end
            end

            if (i_cmd.load_feed) begin
                r_op <= feed_byte;
                r_mh <= 1'b1;
                r_fp <= r_fp + 2'd1;
            end

            if (i_cmd.load_held) begin
                r_op     <= r_held;
                r_mh     <= 1'b0;
                r_held_v <= 1'b0;
            end

            if (i_cmd.comment_start) begin
                r_held_v <= 1'b0;
                r_in_cmt <= 1'b1;
                r_fp     <= r_fp + 2'd1;
            end

            if (i_cmd.proc) begin
                r_after_cr <= d_newline && (r_op == CH_CR);
                if (d_set_cmt) begin
                    r_in_cmt <= 1'b1;
                end else if (d_clr_cmt) begin
                    r_in_cmt <= 1'b0;
                end
                if (d_hold) begin
                    r_held   <= r_op;
                    r_held_v <= 1'b1;
                end
            end

            if (i_cmd.line_inc && (r_line != LINE_MAX)) begin
                r_line <= r_line + LINE_W'(1);
            end

            if (i_cmd.add_char) begin
                if (r_len < LEN_W'(TOKEN_MAX)) begin
                    r_len <= r_len + LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (i_cmd.emit_wr) begin
                r_out_valid <= 1'b1;
                r_out_char  <= r_rd_data;
                r_out_end   <= emit_last;
                r_out_line  <= r_line;
                r_out_trunc <= r_ovf;
                if (emit_last) begin
                    r_len <= '0;
                    r_ovf <= 1'b0;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.tok_clear) begin
                r_len <= '0;
                r_ovf <= 1'b0;
                r_idx <= '0;
            end

            if (do_restart) begin
                r_len      <= '0;
                r_ovf      <= 1'b0;
                r_line     <= LINE_FIRST;
                r_held     <= '0;
                r_held_v   <= 1'b0;
                r_in_cmt   <= 1'b0;
                r_after_cr <= 1'b0;
                r_bom_prog <= '0;
                r_bom_seen <= 1'b0;
                r_last     <= 1'b0;
                r_idx      <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_end   = r_out_end;
    assign o_out_line  = r_out_line;
    assign o_out_trunc = r_out_trunc;

endmodule

@@ rtl/core/text_tokenizer.sv @@
// text_tokenizer splits a byte stream into tokens and sends them out one character per
// request, each tagged with its line number, an end-of-token mark (tlast) and a truncation
// flag (tuser). Spaces, tabs and newlines end a token, the sixteen configured special bytes
// are tokens of their own, the configured one- or two-byte prefix starts a line comment,
// and a leading UTF-8 byte order mark is dropped. Tokens longer than 63 characters keep
// their first 63 and are flagged. tlast on the input marks the final byte of a text: the
// pending token is flushed and the next byte starts a new text at line 1. Bytes are taken
// one at a time: each byte is accepted, then each processing step of it runs in the
// sequencer (load, decide, commit, return), and each token character it releases passes
// through a registered read of the token memory, then the output register. A replayed
// partial byte order mark or a held comment lead byte adds one step each. Output
// back-pressure only stalls the character being sent. Register writes are taken in any
// cycle but must only be made while the block is idle.
module text_tokenizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream, tdata: in_byte[7:0]; tlast: in_last
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    // master stream, tdata: out_char[7:0], out_line[27:8], zero[31:28]; tlast: out_token_end
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [tt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    // tuser: out_truncated[0]
    output logic [0:0]                     o_m_axis_tuser,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tt_pkg::*;

    t_cmd              w_cmd;
    t_status           w_st;
    logic [CHAR_W-1:0] w_char;
    logic [LINE_W-1:0] w_line;
    logic              w_trunc;

    tt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    tt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_char  (w_char),
        .o_out_end   (o_m_axis_tlast),
        .o_out_line  (w_line),
        .o_out_trunc (w_trunc)
    );

    assign o_cfg_ready       = 1'b1;
    assign o_m_axis_tdata    = {TDATA_PAD'(0), w_line, w_char};
    assign o_m_axis_tuser[0] = w_trunc;

`ifndef ASSERT_OFF
    // a character is only moved into the output register when that register can take it
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_wr |-> w_st.out_free)
        else $error("token character loaded into an occupied output register");

    // sending the final character of a token empties the token store
    a_token_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_wr && w_st.emit_last) |=> w_st.tok_empty)
        else $error("token store not empty after its last character was sent");

    // line numbers start at one and saturate, so zero never leaves the block
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_line != '0))
        else $error("token character sent with line number zero");
`endif

endmodule
